// ===== rtl/efp_pkg.sv =====
// efp_pkg: shared types and constants of the encoder frame parser
// used by efp_capture and encoder_frame_parser_core; no dependencies

package efp_pkg;

   // start mark, check value and counter limits
   localparam logic [7:0] MARK_FIRST  = 8'd255;
   localparam logic [7:0] MARK_SECOND = 8'd10;
   localparam logic [7:0] CHECK_VALUE = 8'd170;
   localparam int         SLOT_COUNT  = 9;
   localparam int         SLOT_BITS   = $clog2(SLOT_COUNT);

   typedef logic [5:0] pos_type;

   localparam pos_type POS_START = 6'd1;
   localparam pos_type POS_MAX   = 6'd31;
   localparam pos_type POS_RESET = 6'd63;

   // field positions inside a frame
   localparam pos_type POS_TIME_B3  = 6'd2;
   localparam pos_type POS_TIME_B2  = 6'd3;
   localparam pos_type POS_TIME_B1  = 6'd4;
   localparam pos_type POS_TIME_B0  = 6'd5;
   localparam pos_type POS_RIGHT_HI = 6'd8;
   localparam pos_type POS_RIGHT_LO = 6'd9;
   localparam pos_type POS_LEFT_HI  = 6'd10;
   localparam pos_type POS_LEFT_LO  = 6'd11;
   localparam pos_type POS_CHECK    = 6'd16;

   // slot of each field byte
   localparam logic [SLOT_BITS-1:0] SLOT_TIME_B3  = 4'd0;
   localparam logic [SLOT_BITS-1:0] SLOT_TIME_B2  = 4'd1;
   localparam logic [SLOT_BITS-1:0] SLOT_TIME_B1  = 4'd2;
   localparam logic [SLOT_BITS-1:0] SLOT_TIME_B0  = 4'd3;
   localparam logic [SLOT_BITS-1:0] SLOT_RIGHT_HI = 4'd4;
   localparam logic [SLOT_BITS-1:0] SLOT_RIGHT_LO = 4'd5;
   localparam logic [SLOT_BITS-1:0] SLOT_LEFT_HI  = 4'd6;
   localparam logic [SLOT_BITS-1:0] SLOT_LEFT_LO  = 4'd7;
   localparam logic [SLOT_BITS-1:0] SLOT_CHECK    = 4'd8;

   typedef struct packed {
      logic                 hit;
      logic [SLOT_BITS-1:0] idx;
   } slot_type;

   // decoded frame handed from the capture logic to the result register
   typedef struct packed {
      logic        hit;
      logic [31:0] frame_time;
      logic [15:0] enc_first;
      logic [15:0] enc_second;
   } frame_type;

   // map a position to its field slot
   function automatic slot_type slot_of(input pos_type pos);
      slot_type s;
      s.hit = 1'b1;
      s.idx = SLOT_TIME_B3;
      case (pos)
         POS_TIME_B3:  s.idx = SLOT_TIME_B3;
         POS_TIME_B2:  s.idx = SLOT_TIME_B2;
         POS_TIME_B1:  s.idx = SLOT_TIME_B1;
         POS_TIME_B0:  s.idx = SLOT_TIME_B0;
         POS_RIGHT_HI: s.idx = SLOT_RIGHT_HI;
         POS_RIGHT_LO: s.idx = SLOT_RIGHT_LO;
         POS_LEFT_HI:  s.idx = SLOT_LEFT_HI;
         POS_LEFT_LO:  s.idx = SLOT_LEFT_LO;
         POS_CHECK:    s.idx = SLOT_CHECK;
         default:      s.hit = 1'b0;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/efp_capture.sv =====
// efp_capture: start mark detection, position counter and field byte capture
// depends on efp_pkg

module efp_capture (
   input  logic                clock,
   input  logic                reset,
   input  logic                xfer,
   input  logic [7:0]          in_byte,
   output efp_pkg::frame_type  frame
);

   logic [7:0]                       prev_byte_ff;
   efp_pkg::pos_type                 pos_ff;
   efp_pkg::pos_type                 pos_in;
   logic [efp_pkg::SLOT_COUNT-1:0]   valid_ff;
   logic [7:0]                       bytes_ff [efp_pkg::SLOT_COUNT];
   logic                             is_mark;
   efp_pkg::slot_type                slot;

   // start mark and saturating position advance
   always_comb begin
      is_mark = (prev_byte_ff == efp_pkg::MARK_FIRST) && (in_byte == efp_pkg::MARK_SECOND);
      pos_in  = (pos_ff == efp_pkg::POS_MAX) ? pos_ff : pos_ff + 6'd1;
      slot    = efp_pkg::slot_of(pos_in);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_byte_ff <= '0;
         pos_ff       <= efp_pkg::POS_RESET;
         valid_ff     <= '0;
      end else if (xfer) begin
         prev_byte_ff <= in_byte;
         if (is_mark) begin
            pos_ff   <= efp_pkg::POS_START;
            valid_ff <= '0;
         end else begin
            pos_ff <= pos_in;
            if (slot.hit) begin
               valid_ff[slot.idx] <= 1'b1;
            end
         end
      end
   end

   // field bytes, gated by valid_ff so no reset needed
   always_ff @(posedge clock) begin
      if (xfer && !is_mark && slot.hit) begin
         bytes_ff[slot.idx] <= in_byte;
      end
   end

   // frame completes on a start mark with all fields and a good check byte
   always_comb begin
      frame.hit        = xfer && is_mark && (&valid_ff)
                         && (bytes_ff[efp_pkg::SLOT_CHECK] == efp_pkg::CHECK_VALUE);
      frame.frame_time = {bytes_ff[efp_pkg::SLOT_TIME_B3], bytes_ff[efp_pkg::SLOT_TIME_B2],
                          bytes_ff[efp_pkg::SLOT_TIME_B1], bytes_ff[efp_pkg::SLOT_TIME_B0]};
      frame.enc_first  = {bytes_ff[efp_pkg::SLOT_RIGHT_HI], bytes_ff[efp_pkg::SLOT_RIGHT_LO]};
      frame.enc_second = {bytes_ff[efp_pkg::SLOT_LEFT_HI], bytes_ff[efp_pkg::SLOT_LEFT_LO]};
   end

endmodule

// ===== rtl/encoder_frame_parser_core.sv =====
// encoder_frame_parser_core: top level of the serial encoder frame parser
// result: a frame appears on rsp_ in the cycle after the transfer of its closing start mark
// throughput: one byte per cycle while req_stall is low, set by the single result register; req_stall is high
//   only while a result waits and rsp_stall is high
// reset: synchronous, active high; clears the previous byte, sets the position to 63 (wraps to 0 on the next byte),
//   clears all capture flags and empties the result register
// depends on efp_pkg and efp_capture

module encoder_frame_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_frame_time,
   output logic [15:0] rsp_enc_first,
   output logic [15:0] rsp_enc_second
);

   logic               rsp_valid_ff;
   logic [31:0]        frame_time_ff;
   logic [15:0]        enc_first_ff;
   logic [15:0]        enc_second_ff;
   logic               req_xfer;
   efp_pkg::frame_type frame;

   // input transfer whenever the result register is free or draining
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_xfer  = req_valid && !req_stall;

   efp_capture u_capture (
      .clock   (clock),
      .reset   (reset),
      .xfer    (req_xfer),
      .in_byte (req_in_byte),
      .frame   (frame)
   );

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         rsp_valid_ff <= frame.hit;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (frame.hit) begin
         frame_time_ff <= frame.frame_time;
         enc_first_ff  <= frame.enc_first;
         enc_second_ff <= frame.enc_second;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_time = frame_time_ff;
   assign rsp_enc_first  = enc_first_ff;
   assign rsp_enc_second = enc_second_ff;

   // a new result only follows an input transfer
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_xfer))
      else $error("result appeared without an input transfer");

   // an empty result register never holds off the input
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> !req_stall)
      else $error("input stalled while result register empty");

   // only the second byte of a start mark can close a frame
   a_mark_only: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_in_byte != efp_pkg::MARK_SECOND) |=> !rsp_valid_ff)
      else $error("frame emitted on a byte that is not a start mark");

endmodule
